[design/rdcu_pkg.sv]
// ----------------------------------------------------------------------------
// rdcu_pkg
// Shared constants, register codes and saturating helpers for the
// reaction-diffusion cell update pipeline.
// ----------------------------------------------------------------------------
package rdcu_pkg;

  localparam int FRAC_BITS_DEF = 24;

  // configuration port
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_R0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV = 3'd6;

  localparam logic [CFG_W-1:0] RST_R0  = 31'd19629343;
  localparam logic [CFG_W-1:0] RST_RD  = 31'd21810381;
  localparam logic [CFG_W-1:0] RST_MV  = 31'd2516582;
  localparam logic [CFG_W-1:0] RST_DS  = 31'd167772;
  localparam logic [CFG_W-1:0] RST_DI  = 31'd4194304;
  localparam logic [CFG_W-1:0] RST_DT  = 31'd419430;
  localparam logic [CFG_W-1:0] RST_INV = 31'd150994944;

  // field widths
  localparam int VAL_W = 32;
  localparam int SUM_W = VAL_W + 1;
  localparam int LAP_W = VAL_W + 3;
  localparam int WIDE_W = 64;

  // unit latencies
  localparam int MUL_LAT   = 4;
  localparam int DIV_NUM_W = 2 * VAL_W - 1;
  localparam int DIV_DEN_W = SUM_W;
  localparam int DIV_LAT   = DIV_NUM_W + 2;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [VAL_W-1:0]  val_t;

  localparam wide_t WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam wide_t WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
  localparam val_t  VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t  VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};

  function automatic wide_t sat_add(wide_t a, wide_t b);
    wide_t sum;
    sum = a + b;
    if (a[WIDE_W-1] == b[WIDE_W-1] && sum[WIDE_W-1] != a[WIDE_W-1]) begin
      sum = a[WIDE_W-1] ? WIDE_MIN : WIDE_MAX;
    end
    return sum;
  endfunction

  function automatic wide_t sat_sub(wide_t a, wide_t b);
    wide_t dif;
    dif = a - b;
    if (a[WIDE_W-1] != b[WIDE_W-1] && dif[WIDE_W-1] != a[WIDE_W-1]) begin
      dif = a[WIDE_W-1] ? WIDE_MIN : WIDE_MAX;
    end
    return dif;
  endfunction

  function automatic val_t clamp32(wide_t x);
    val_t res;
    if (x[WIDE_W-1:VAL_W-1] == '0 || x[WIDE_W-1:VAL_W-1] == '1) begin
      res = x[VAL_W-1:0];
    end else begin
      res = x[WIDE_W-1] ? VAL_MIN : VAL_MAX;
    end
    return res;
  endfunction

endpackage

[design/rdcu_if.sv]
// ----------------------------------------------------------------------------
// rdcu channel interfaces
// Valid/ready channels for cell requests and updated cell results.
// ----------------------------------------------------------------------------
interface rdcu_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] center_s;
  logic signed [31:0] north_s;
  logic signed [31:0] south_s;
  logic signed [31:0] west_s;
  logic signed [31:0] east_s;
  logic signed [31:0] center_i;
  logic signed [31:0] north_i;
  logic signed [31:0] south_i;
  logic signed [31:0] west_i;
  logic signed [31:0] east_i;

  modport source (
    output valid, center_s, north_s, south_s, west_s, east_s,
    output center_i, north_i, south_i, west_i, east_i,
    input  ready
  );
  modport sink (
    input  valid, center_s, north_s, south_s, west_s, east_s,
    input  center_i, north_i, south_i, west_i, east_i,
    output ready
  );
endinterface

interface rdcu_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] new_s;
  logic signed [31:0] new_i;
  logic zero_total;

  modport source (output valid, new_s, new_i, zero_total, input ready);
  modport sink (input valid, new_s, new_i, zero_total, output ready);
endinterface

[design/rdcu_delay.sv]
// ----------------------------------------------------------------------------
// rdcu_delay
// Stallable shift line that keeps operands aligned with the pipeline.
// ----------------------------------------------------------------------------
module rdcu_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int k = 1; k < DEPTH; k++) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

[design/rdcu_fxmul.sv]
// ----------------------------------------------------------------------------
// rdcu_fxmul
// Four-stage signed fixed-point multiply: sign/magnitude, 32x32 partial
// products, 128-bit sum, then shift with saturation to 64 bits.
// ----------------------------------------------------------------------------
module rdcu_fxmul #(
  parameter int FRAC_BITS = rdcu_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  rdcu_pkg::wide_t     a,
  input  rdcu_pkg::wide_t     b,
  output rdcu_pkg::wide_t     p
);

  logic [63:0]  ua_r, ub_r;
  logic         neg1_r, neg2_r, neg3_r;
  logic [63:0]  pp00_r, pp01_r, pp10_r, pp11_r;
  logic [127:0] prod_r;
  logic [127:0] shifted;
  logic [63:0]  mag;
  logic         over;
  rdcu_pkg::wide_t p_nxt, p_r;

  always_comb begin
    shifted = prod_r >> FRAC_BITS;
    mag     = shifted[63:0];
    over    = (|shifted[127:64]) || mag[63];
    if (neg3_r) begin
      p_nxt = over ? rdcu_pkg::WIDE_MIN : rdcu_pkg::wide_t'(-mag);
    end else begin
      p_nxt = over ? rdcu_pkg::WIDE_MAX : rdcu_pkg::wide_t'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r   <= a[63] ? 64'(-a) : 64'(a);
      ub_r   <= b[63] ? 64'(-b) : 64'(b);
      neg1_r <= a[63] ^ b[63];

      pp00_r <= 64'(ua_r[31:0])  * 64'(ub_r[31:0]);
      pp01_r <= 64'(ua_r[31:0])  * 64'(ub_r[63:32]);
      pp10_r <= 64'(ua_r[63:32]) * 64'(ub_r[31:0]);
      pp11_r <= 64'(ua_r[63:32]) * 64'(ub_r[63:32]);
      neg2_r <= neg1_r;

      prod_r <= 128'(pp00_r) + (128'(pp01_r) << 32) + (128'(pp10_r) << 32)
              + (128'(pp11_r) << 64);
      neg3_r <= neg2_r;

      p_r    <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

[design/rdcu_div.sv]
// ----------------------------------------------------------------------------
// rdcu_div
// Pipelined restoring divider, one quotient bit per stage, for the
// incidence ratio; quotient truncates toward zero, zero divisor gives zero.
// ----------------------------------------------------------------------------
module rdcu_div (
  input  logic                                  clk,
  input  logic                                  en,
  input  rdcu_pkg::wide_t                       num,
  input  logic signed [rdcu_pkg::DIV_DEN_W-1:0] den,
  output rdcu_pkg::wide_t                       quo
);

  localparam int NW = rdcu_pkg::DIV_NUM_W;
  localparam int DW = rdcu_pkg::DIV_DEN_W;

  logic [NW-1:0] q_r    [NW+1];
  logic [DW-1:0] rem_r  [NW+1];
  logic [DW-1:0] d_r    [NW+1];
  logic          neg_r  [NW+1];
  logic          zero_r [NW+1];

  logic [63:0]   num_mag;
  logic [DW-1:0] den_mag;
  rdcu_pkg::wide_t quo_r;

  always_comb begin
    num_mag = num[63] ? 64'(-num) : 64'(num);
    den_mag = den[DW-1] ? DW'(-den) : DW'(den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0]    <= num_mag[NW-1:0];
      rem_r[0]  <= '0;
      d_r[0]    <= den_mag;
      neg_r[0]  <= num[63] ^ den[DW-1];
      zero_r[0] <= (den == '0);
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [NW-1:0] q_nxt;

    always_comb begin
      trial   = {rem_r[k], q_r[k][NW-1]};
      ge      = trial >= {1'b0, d_r[k]};
      rem_nxt = ge ? DW'(trial - {1'b0, d_r[k]}) : trial[DW-1:0];
      q_nxt   = {q_r[k][NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k+1]    <= q_nxt;
        rem_r[k+1]  <= rem_nxt;
        d_r[k+1]    <= d_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[NW]) begin
        quo_r <= '0;
      end else if (neg_r[NW]) begin
        quo_r <= rdcu_pkg::wide_t'(-(64'(q_r[NW])));
      end else begin
        quo_r <= rdcu_pkg::wide_t'(64'(q_r[NW]));
      end
    end
  end

  assign quo = quo_r;

endmodule

[design/si_reaction_diffusion_cell_update.sv]
// ----------------------------------------------------------------------------
// si_reaction_diffusion_cell_update
// One explicit-Euler step of an interior S/I cell with a five-point stencil.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one cell request: center S and I plus the four neighbours
//   of each, signed Q8.24. out_ch returns new_s, new_i (saturated to 32 bits)
//   and zero_total, set when S + I was zero and the incidence was forced to 0.
//   Coefficients are written through cfg_we/cfg_index/cfg_data while no
//   request is in flight; an index past the last register is ignored.
// Timing:
//   one request is taken every cycle while in_ch.ready is high. The latency is set by
//   the 63-stage bit-per-stage divider for S*I/(S+I) followed by the chain of
//   four-stage multipliers.
// Stalls:
//   an output register plus a one-entry skid buffer sit at the end. While the
//   receiver holds ready low, the pipeline keeps moving until the skid entry
//   fills; then in_ch.ready drops and the whole pipeline holds in place.
// Reset:
//   rst_n clears all valid bits, including those of both output entries, and
//   restores the default coefficients.
// ----------------------------------------------------------------------------
module si_reaction_diffusion_cell_update #(
  parameter int FRAC_BITS = rdcu_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  rdcu_in_if.sink                            in_ch,
  rdcu_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [rdcu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rdcu_pkg::CFG_W-1:0]         cfg_data
);

  localparam int L       = rdcu_pkg::MUL_LAT;
  localparam int T_RINC  = 1 + rdcu_pkg::DIV_LAT + L;
  localparam int T_FIN   = T_RINC + 3 + L;
  localparam int VW      = rdcu_pkg::VAL_W;
  localparam int SW      = rdcu_pkg::SUM_W;
  localparam int LW      = rdcu_pkg::LAP_W;
  localparam int WW      = rdcu_pkg::WIDE_W;
  localparam rdcu_pkg::wide_t FX_ONE = rdcu_pkg::wide_t'(64'sd1 <<< FRAC_BITS);

  // coefficients
  logic [rdcu_pkg::CFG_W-1:0] r0_r, rd_r, mv_r, ds_r, di_r, dt_r, inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r0_r  <= rdcu_pkg::RST_R0;
      rd_r  <= rdcu_pkg::RST_RD;
      mv_r  <= rdcu_pkg::RST_MV;
      ds_r  <= rdcu_pkg::RST_DS;
      di_r  <= rdcu_pkg::RST_DI;
      dt_r  <= rdcu_pkg::RST_DT;
      inv_r <= rdcu_pkg::RST_INV;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rdcu_pkg::REG_R0:  r0_r  <= cfg_data;
        rdcu_pkg::REG_RD:  rd_r  <= cfg_data;
        rdcu_pkg::REG_MV:  mv_r  <= cfg_data;
        rdcu_pkg::REG_DS:  ds_r  <= cfg_data;
        rdcu_pkg::REG_DI:  di_r  <= cfg_data;
        rdcu_pkg::REG_DT:  dt_r  <= cfg_data;
        rdcu_pkg::REG_INV: inv_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic en;
  logic skid_v_r, out_valid_r;
  logic [T_FIN:0] vld_r;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[T_FIN-1:0], in_ch.valid};
    end
  end

  // stage 0: request register
  rdcu_pkg::val_t cs_r, ns_r, ss_r, ws_r, es_r;
  rdcu_pkg::val_t ci_r, ni_r, si_r, wi_r, ei_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cs_r <= in_ch.center_s;
      ns_r <= in_ch.north_s;
      ss_r <= in_ch.south_s;
      ws_r <= in_ch.west_s;
      es_r <= in_ch.east_s;
      ci_r <= in_ch.center_i;
      ni_r <= in_ch.north_i;
      si_r <= in_ch.south_i;
      wi_r <= in_ch.west_i;
      ei_r <= in_ch.east_i;
    end
  end

  // stage 1: sums, laplacians and S*I
  logic signed [SW-1:0] total_nxt, total1_r;
  logic signed [LW-1:0] lap_s_nxt, lap_i_nxt, lap_s1_r, lap_i1_r;
  rdcu_pkg::wide_t      prod_nxt, prod1_r;
  rdcu_pkg::val_t       s1_r, i1_r;
  logic                 zero1_r;

  always_comb begin
    total_nxt = SW'(cs_r) + SW'(ci_r);
    lap_s_nxt = LW'(ns_r) + LW'(ss_r) + LW'(ws_r) + LW'(es_r) - (LW'(cs_r) <<< 2);
    lap_i_nxt = LW'(ni_r) + LW'(si_r) + LW'(wi_r) + LW'(ei_r) - (LW'(ci_r) <<< 2);
    prod_nxt  = WW'(cs_r) * WW'(ci_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total1_r <= total_nxt;
      lap_s1_r <= lap_s_nxt;
      lap_i1_r <= lap_i_nxt;
      prod1_r  <= prod_nxt;
      s1_r     <= cs_r;
      i1_r     <= ci_r;
      zero1_r  <= (total_nxt == '0);
    end
  end

  // coefficient products, started alongside the request
  rdcu_pkg::wide_t mvrd_p, dsinv_p, diinv_p;

  rdcu_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_mvrd (
    .clk(clk), .en(en), .a(WW'(mv_r)), .b(WW'(rd_r)), .p(mvrd_p)
  );
  rdcu_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_dsinv (
    .clk(clk), .en(en), .a(WW'(ds_r)), .b(WW'(inv_r)), .p(dsinv_p)
  );
  rdcu_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_diinv (
    .clk(clk), .en(en), .a(WW'(di_r)), .b(WW'(inv_r)), .p(diinv_p)
  );

  // growth term: ((v*Rd)*T)*(1-T)
  logic signed [SW-1:0] total_l, total_2l;
  rdcu_pkg::wide_t      grow1_p, grow_p, one_minus;

  rdcu_delay #(.WIDTH(SW), .DEPTH(L-1)) u_dly_total_a (
    .clk(clk), .en(en), .din(total1_r), .dout(total_l)
  );
  rdcu_delay #(.WIDTH(SW), .DEPTH(L)) u_dly_total_b (
    .clk(clk), .en(en), .din(total_l), .dout(total_2l)
  );

  assign one_minus = FX_ONE - WW'(total_2l);

  rdcu_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_grow1 (
    .clk(clk), .en(en), .a(mvrd_p), .b(WW'(total_l)), .p(grow1_p)
  );
  rdcu_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_grow2 (
    .clk(clk), .en(en), .a(grow1_p), .b(one_minus), .p(grow_p)
  );

  // diffusion terms
  logic signed [LW-1:0] lap_s_l, lap_i_l;
  rdcu_pkg::wide_t      dfs_p, dfi_p;

  rdcu_delay #(.WIDTH(2*LW), .DEPTH(L-1)) u_dly_lap (
    .clk(clk), .en(en), .din({lap_s1_r, lap_i1_r}), .dout({lap_s_l, lap_i_l})
  );
  rdcu_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_dfs (
    .clk(clk), .en(en), .a(WW'(lap_s_l)), .b(dsinv_p), .p(dfs_p)
  );
  rdcu_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_dfi (
    .clk(clk), .en(en), .a(WW'(lap_i_l)), .b(diinv_p), .p(dfi_p)
  );

  // loss term v*S
  rdcu_pkg::wide_t mvs_p;

  rdcu_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_mvs (
    .clk(clk), .en(en), .a(WW'(mv_r)), .b(WW'(s1_r)), .p(mvs_p)
  );

  // incidence S*I/T and R0*inc
  rdcu_pkg::wide_t inc_q, rinc_p;

  rdcu_div u_div (
    .clk(clk), .en(en), .num(prod1_r), .den(total1_r), .quo(inc_q)
  );
  rdcu_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_rinc (
    .clk(clk), .en(en), .a(WW'(r0_r)), .b(inc_q), .p(rinc_p)
  );

  // align side operands with the incidence
  rdcu_pkg::wide_t      grow_d, mvs_d, dfs_d, dfi_d;
  rdcu_pkg::val_t       i_d;
  rdcu_pkg::val_t       s_d;
  logic                 zero_d;

  rdcu_delay #(.WIDTH(WW), .DEPTH(T_RINC - 3*L)) u_dly_grow (
    .clk(clk), .en(en), .din(grow_p), .dout(grow_d)
  );
  rdcu_delay #(.WIDTH(WW), .DEPTH(T_RINC - L)) u_dly_mvs (
    .clk(clk), .en(en), .din(mvs_p), .dout(mvs_d)
  );
  rdcu_delay #(.WIDTH(VW), .DEPTH(T_RINC - 1)) u_dly_i (
    .clk(clk), .en(en), .din(i1_r), .dout(i_d)
  );
  rdcu_delay #(.WIDTH(2*WW), .DEPTH(T_RINC + 2 - 2*L)) u_dly_diff (
    .clk(clk), .en(en), .din({dfs_p, dfi_p}), .dout({dfs_d, dfi_d})
  );
  rdcu_delay #(.WIDTH(VW+1), .DEPTH(T_FIN - 1)) u_dly_s (
    .clk(clk), .en(en), .din({s1_r, zero1_r}), .dout({s_d, zero_d})
  );

  // reaction and sum stages
  rdcu_pkg::wide_t x_r, gi_r, fs_r, gi2_r, as_r, ai_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= rdcu_pkg::sat_sub(grow_d, rinc_p);
      gi_r  <= rdcu_pkg::sat_sub(rinc_p, WW'(i_d));
      fs_r  <= rdcu_pkg::sat_sub(x_r, mvs_d);
      gi2_r <= gi_r;
      as_r  <= rdcu_pkg::sat_add(fs_r, dfs_d);
      ai_r  <= rdcu_pkg::sat_add(gi2_r, dfi_d);
    end
  end

  // i is needed again at the end
  rdcu_pkg::val_t i_d_final;

  rdcu_delay #(.WIDTH(VW), .DEPTH(T_FIN - T_RINC)) u_dly_i_fin (
    .clk(clk), .en(en), .din(i_d), .dout(i_d_final)
  );

  // time step and final update
  rdcu_pkg::wide_t dts_p, dti_p;
  rdcu_pkg::val_t  fin_s, fin_i;

  rdcu_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_dts (
    .clk(clk), .en(en), .a(WW'(dt_r)), .b(as_r), .p(dts_p)
  );
  rdcu_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_dti (
    .clk(clk), .en(en), .a(WW'(dt_r)), .b(ai_r), .p(dti_p)
  );

  assign fin_s = rdcu_pkg::clamp32(rdcu_pkg::sat_add(WW'(s_d), dts_p));
  assign fin_i = rdcu_pkg::clamp32(rdcu_pkg::sat_add(WW'(i_d_final), dti_p));

  // output register and skid entry
  logic           take;
  rdcu_pkg::val_t out_s_r, out_i_r, skid_s_r, skid_i_r;
  logic           out_z_r, skid_z_r;

  assign take = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (vld_r[T_FIN]) begin
      if (out_valid_r && !take) begin
        skid_v_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        out_s_r <= skid_s_r;
        out_i_r <= skid_i_r;
        out_z_r <= skid_z_r;
      end
    end else if (vld_r[T_FIN]) begin
      if (out_valid_r && !take) begin
        skid_s_r <= fin_s;
        skid_i_r <= fin_i;
        skid_z_r <= zero_d;
      end else begin
        out_s_r <= fin_s;
        out_i_r <= fin_i;
        out_z_r <= zero_d;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.new_s      = out_s_r;
  assign out_ch.new_i      = out_i_r;
  assign out_ch.zero_total = out_z_r;

endmodule

[sim/rdcu_update_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rdcu_update_checker
// Watches the request, result and coefficient ports of the cell update
// block, predicts every updated cell in fixed point and compares the
// results in order, field by field.
// ----------------------------------------------------------------------------
module rdcu_update_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  rdcu_in_if                             in_ch,
  rdcu_out_if                            out_ch,
  input  logic                           cfg_we,
  input  logic [rdcu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rdcu_pkg::CFG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             cells_waiting,
  output int                             cells_checked,
  output int                             zero_total_seen
);

  localparam int FB = rdcu_pkg::FRAC_BITS_DEF;
  localparam longint Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint Q_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] new_s;
    logic signed [31:0] new_i;
    logic               zero_total;
  } cell_update_t;

  logic [rdcu_pkg::CFG_W-1:0] coef_r0, coef_rd, coef_mv, coef_ds;
  logic [rdcu_pkg::CFG_W-1:0] coef_di, coef_dt, coef_inv;
  cell_update_t     expected_updates[$];

  // sign and magnitude product, truncated toward zero, saturated to 64 bits
  function automatic longint mul_q(longint a, longint b);
    logic [63:0]  ma, mb, q;
    logic [127:0] p;
    logic         over;
    ma = a[63] ? 64'(-a) : 64'(a);
    mb = b[63] ? 64'(-b) : 64'(b);
    p = {64'd0, ma} * {64'd0, mb};
    q = p[FB+63:FB];
    over = |p[127:FB+64];
    if (a[63] ^ b[63]) begin
      if (over || q[63]) return Q_MIN;
      return -longint'(q);
    end
    if (over || q[63]) return Q_MAX;
    return longint'(q);
  endfunction

  function automatic longint add_q(longint a, longint b);
    logic signed [64:0] t;
    t = {a[63], a} + {b[63], b};
    if (t > 65'sd0 && t[64:63] == 2'b01) return Q_MAX;
    if (t[64:63] == 2'b10) return Q_MIN;
    return longint'(t[63:0]);
  endfunction

  function automatic longint sub_q(longint a, longint b);
    logic signed [64:0] t;
    t = {a[63], a} - {b[63], b};
    if (t[64:63] == 2'b01) return Q_MAX;
    if (t[64:63] == 2'b10) return Q_MIN;
    return longint'(t[63:0]);
  endfunction

  function automatic logic signed [31:0] clip32(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic longint coef(logic [rdcu_pkg::CFG_W-1:0] c);
    return longint'({33'd0, c});
  endfunction

  function automatic cell_update_t update_cell(
    logic signed [31:0] s, n_s, so_s, w_s, e_s,
    logic signed [31:0] i, n_i, so_i, w_i, e_i
  );
    cell_update_t r;
    longint sv, iv, total, one, inc, grow, rinc, fs, gi, lap_s, lap_i;
    sv = s;
    iv = i;
    total = sv + iv;
    one = longint'(1) <<< FB;
    inc = (total == 0) ? 0 : (sv * iv) / total;
    lap_s = longint'(n_s) + longint'(so_s) + longint'(w_s) + longint'(e_s) - 4 * sv;
    lap_i = longint'(n_i) + longint'(so_i) + longint'(w_i) + longint'(e_i) - 4 * iv;
    grow = mul_q(mul_q(mul_q(coef(coef_mv), coef(coef_rd)), total), one - total);
    rinc = mul_q(coef(coef_r0), inc);
    fs = sub_q(sub_q(grow, rinc), mul_q(coef(coef_mv), sv));
    gi = sub_q(rinc, iv);
    fs = add_q(fs, mul_q(lap_s, mul_q(coef(coef_ds), coef(coef_inv))));
    gi = add_q(gi, mul_q(lap_i, mul_q(coef(coef_di), coef(coef_inv))));
    r.new_s = clip32(add_q(sv, mul_q(coef(coef_dt), fs)));
    r.new_i = clip32(add_q(iv, mul_q(coef(coef_dt), gi)));
    r.zero_total = (total == 0);
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", field, got, want,
             cells_checked);
    fail_count++;
  endtask

  assign cells_waiting = expected_updates.size();

  always @(posedge clk) begin
    cell_update_t want;
    if (!rst_n) begin
      coef_r0 <= rdcu_pkg::RST_R0;
      coef_rd <= rdcu_pkg::RST_RD;
      coef_mv <= rdcu_pkg::RST_MV;
      coef_ds <= rdcu_pkg::RST_DS;
      coef_di <= rdcu_pkg::RST_DI;
      coef_dt <= rdcu_pkg::RST_DT;
      coef_inv <= rdcu_pkg::RST_INV;
      expected_updates.delete();
      fail_count = 0;
      cells_checked = 0;
      zero_total_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rdcu_pkg::REG_R0:  coef_r0 <= cfg_data;
          rdcu_pkg::REG_RD:  coef_rd <= cfg_data;
          rdcu_pkg::REG_MV:  coef_mv <= cfg_data;
          rdcu_pkg::REG_DS:  coef_ds <= cfg_data;
          rdcu_pkg::REG_DI:  coef_di <= cfg_data;
          rdcu_pkg::REG_DT:  coef_dt <= cfg_data;
          rdcu_pkg::REG_INV: coef_inv <= cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_updates.push_back(update_cell(
          in_ch.center_s, in_ch.north_s, in_ch.south_s, in_ch.west_s, in_ch.east_s,
          in_ch.center_i, in_ch.north_i, in_ch.south_i, in_ch.west_i, in_ch.east_i));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_updates.size() == 0) begin
          report("unexpected result new_s", out_ch.new_s, 0);
        end else begin
          want = expected_updates.pop_front();
          if (out_ch.new_s !== want.new_s) report("new_s", out_ch.new_s, want.new_s);
          if (out_ch.new_i !== want.new_i) report("new_i", out_ch.new_i, want.new_i);
          if (out_ch.zero_total !== want.zero_total)
            report("zero_total", out_ch.zero_total, want.zero_total);
          if (want.zero_total) zero_total_seen++;
          cells_checked++;
        end
      end
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams cell requests into the reaction-diffusion update block under
// several coefficient settings with random idling on both channels; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic signed [31:0] v[10];
  } cell_req_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [rdcu_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rdcu_pkg::CFG_W-1:0]     cfg_data;
  logic                           req_taken;
  logic                           idle_on;
  int                   fail_count, cells_waiting, cells_checked, zero_total_seen;
  int                   sent;

  rdcu_in_if  in_ch ();
  rdcu_out_if out_ch ();

  si_reaction_diffusion_cell_update i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rdcu_update_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .cells_waiting   (cells_waiting),
    .cells_checked   (cells_checked),
    .zero_total_seen (zero_total_seen)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) req_taken <= in_ch.valid && in_ch.ready;

  always @(negedge clk) begin
    out_ch.ready <= idle_on ? ($urandom_range(99) >= 26) : 1'b1;
  end

  task automatic send_cell(cell_req_t c);
    while (idle_on && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.center_s <= c.v[0];
    in_ch.north_s  <= c.v[1];
    in_ch.south_s  <= c.v[2];
    in_ch.west_s   <= c.v[3];
    in_ch.east_s   <= c.v[4];
    in_ch.center_i <= c.v[5];
    in_ch.north_i  <= c.v[6];
    in_ch.south_i  <= c.v[7];
    in_ch.west_i   <= c.v[8];
    in_ch.east_i   <= c.v[9];
    @(negedge clk);
    while (!req_taken) @(negedge clk);
    sent++;
  endtask

  task automatic write_coef(logic [rdcu_pkg::CFG_IDX_W-1:0] idx,
                            logic [rdcu_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // let the pipeline empty before touching coefficients
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (cells_waiting != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic cell_req_t fill_cell(logic signed [31:0] s, logic signed [31:0] i,
                                          logic signed [31:0] nb_s, logic signed [31:0] nb_i);
    cell_req_t c;
    c.v[0] = s;
    c.v[5] = i;
    for (int k = 1; k < 5; k++) begin
      c.v[k] = nb_s;
      c.v[k+5] = nb_i;
    end
    return c;
  endfunction

  // mostly plausible population levels, sometimes any 32-bit pattern
  function automatic cell_req_t random_cell();
    cell_req_t c;
    int        mode;
    mode = $urandom_range(99);
    for (int k = 0; k < 10; k++) begin
      if (mode < 60) c.v[k] = $urandom_range(32'h0200_0000);
      else if (mode < 75) c.v[k] = $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
      else c.v[k] = $urandom;
    end
    // incidence denominator of zero
    if ($urandom_range(99) < 6) c.v[5] = -c.v[0];
    return c;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_cell(random_cell());
  endtask

  task automatic run_directed();
    cell_req_t c;
    logic signed [31:0] mx, mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    send_cell(fill_cell(0, 0, 0, 0));
    send_cell(fill_cell(32'sh0100_0000, -32'sh0100_0000, 0, 0));
    send_cell(fill_cell(mx, mn + 1, mx, mn));
    send_cell(fill_cell(mn, mx, mn, mx));
    send_cell(fill_cell(mx, mx, mx, mx));
    send_cell(fill_cell(mn, mn, mn, mn));
    send_cell(fill_cell(mx, mx, mn, mn));
    send_cell(fill_cell(mn, mn, mx, mx));
    send_cell(fill_cell(mn, 0, 0, 0));
    send_cell(fill_cell(0, mn, 0, 0));
    send_cell(fill_cell(32'sh00E0_0000, 32'sh0020_0000, 32'sh00C0_0000, 32'sh0030_0000));
    send_cell(fill_cell(32'sh0100_0000, 32'sh0000_0001, 32'sh0100_0000, 0));
    send_cell(fill_cell(-32'sh0080_0000, 32'sh0040_0000, 32'sh0020_0000, -1));
    send_cell(fill_cell(1, -1, -1, 1));
    c = fill_cell(0, 0, 0, 0);
    for (int k = 0; k < 10; k++) c.v[k] = (k % 2) ? mx : mn;
    send_cell(c);
    for (int k = 0; k < 10; k++) c.v[k] = (k % 2) ? mn : mx;
    send_cell(c);
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    idle_on      = 1'b1;
    sent         = 0;
    in_ch.valid  = 1'b0;
    {in_ch.center_s, in_ch.north_s, in_ch.south_s, in_ch.west_s, in_ch.east_s} = '0;
    {in_ch.center_i, in_ch.north_i, in_ch.south_i, in_ch.west_i, in_ch.east_i} = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset coefficients
    run_directed();
    run_random(240);
    drain();

    // every coefficient at its largest
    for (int r = rdcu_pkg::REG_R0; r <= rdcu_pkg::REG_INV; r++)
      write_coef(r[rdcu_pkg::CFG_IDX_W-1:0], '1);
    run_directed();
    run_random(150);
    drain();

    // every coefficient zero, output must follow the inputs
    for (int r = rdcu_pkg::REG_R0; r <= rdcu_pkg::REG_INV; r++)
      write_coef(r[rdcu_pkg::CFG_IDX_W-1:0], '0);
    run_random(120);
    drain();

    // random coefficients, long stretch without idling
    for (int r = rdcu_pkg::REG_R0; r <= rdcu_pkg::REG_INV; r++)
      write_coef(r[rdcu_pkg::CFG_IDX_W-1:0], rdcu_pkg::CFG_W'($urandom));
    idle_on = 1'b0;
    run_random(300);
    idle_on = 1'b1;
    drain();

    // typical magnitudes near the defaults
    for (int r = rdcu_pkg::REG_R0; r <= rdcu_pkg::REG_INV; r++)
      write_coef(r[rdcu_pkg::CFG_IDX_W-1:0],
                 rdcu_pkg::CFG_W'($urandom_range(31'h0400_0000)));
    run_random(220);
    drain();

    // defaults again, plus a write past the last register that must be ignored
    write_coef(rdcu_pkg::REG_R0, rdcu_pkg::RST_R0);
    write_coef(rdcu_pkg::REG_RD, rdcu_pkg::RST_RD);
    write_coef(rdcu_pkg::REG_MV, rdcu_pkg::RST_MV);
    write_coef(rdcu_pkg::REG_DS, rdcu_pkg::RST_DS);
    write_coef(rdcu_pkg::REG_DI, rdcu_pkg::RST_DI);
    write_coef(rdcu_pkg::REG_DT, rdcu_pkg::RST_DT);
    write_coef(rdcu_pkg::REG_INV, rdcu_pkg::RST_INV);
    write_coef(rdcu_pkg::CFG_IDX_W'(rdcu_pkg::REG_INV + 1), '1);
    run_directed();
    run_random(180);
    drain();

    $display("sent %0d cell requests over six coefficient settings", sent);
    $display("checked %0d results, %0d with a zero S+I total", cells_checked,
             zero_total_seen);
    if (fail_count == 0 && cells_waiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

endmodule
